// ----- rtl/core/ccc_pkg.sv -----
// Package for the cell color classifier: color codes, channel indexes,
// fixed widths and the per-pixel and per-average decision functions.
// No dependencies.
package ccc_pkg;

   // Width of one color channel and of one running channel sum.
   localparam int CHAN_W = 8;
   localparam int SUM_W  = 13;

   // Default number of pixels in one cell window.
   localparam int CELL_PIXELS_DEF = 25;

   // Widths of the packed stream payloads.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // Color codes: blue is bit 2, green bit 1, red bit 0.
   typedef enum logic [2:0] {
      COLOR_BLACK  = 3'd0,
      COLOR_RED    = 3'd1,
      COLOR_GREEN  = 3'd2,
      COLOR_YELLOW = 3'd3,
      COLOR_BLUE   = 3'd4,
      COLOR_PURPLE = 3'd5,
      COLOR_CYAN   = 3'd6,
      COLOR_WHITE  = 3'd7
   } color_type;

   // Channel positions used by the max/min/mid decision.
   localparam logic [1:0] CH_BLUE  = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_RED   = 2'd2;

   // Pure-color threshold rule; the first rule that holds wins.
   // Black means that no rule matched.
   function automatic color_type pure_match(input logic [CHAN_W-1:0] b,
                                            input logic [CHAN_W-1:0] g,
                                            input logic [CHAN_W-1:0] r);
      color_type res;
      if ((b <= 8'd50 && g <= 8'd50 && r >= 8'd100) ||
          (b <= 8'd100 && g <= 8'd100 && r >= 8'd200)) begin
         res = COLOR_RED;
      end else if ((b <= 8'd50 && g >= 8'd100 && r <= 8'd50) ||
                   (b <= 8'd100 && g >= 8'd200 && r <= 8'd100)) begin
         res = COLOR_GREEN;
      end else if (b <= 8'd60 && g >= 8'd190 && r >= 8'd190) begin
         res = COLOR_YELLOW;
      end else if ((b >= 8'd100 && g <= 8'd50 && r <= 8'd50) ||
                   (b >= 8'd200 && g <= 8'd100 && r <= 8'd100)) begin
         res = COLOR_BLUE;
      end else if (b >= 8'd190 && g <= 8'd60 && r >= 8'd190) begin
         res = COLOR_PURPLE;
      end else if (b >= 8'd190 && g >= 8'd190 && r <= 8'd60) begin
         res = COLOR_CYAN;
      end else if (b >= 8'd190 && g >= 8'd190 && r >= 8'd190) begin
         res = COLOR_WHITE;
      end else begin
         res = COLOR_BLACK;
      end
      return res;
   endfunction

   // Max/min/mid decision on the three averages. Ties for max or min go
   // to the first channel in the order blue, green, red.
   function automatic color_type judge(input logic [CHAN_W-1:0] b,
                                       input logic [CHAN_W-1:0] g,
                                       input logic [CHAN_W-1:0] r);
      logic [1:0]        maxp;
      logic [1:0]        minp;
      logic [1:0]        midp;
      logic [CHAN_W-1:0] mx;
      logic [CHAN_W-1:0] mn;
      logic [CHAN_W-1:0] md;
      logic [CHAN_W:0]   up2;
      logic [CHAN_W:0]   dn;
      logic [CHAN_W+1:0] level;
      logic              mid_on;
      logic              all_on;
      logic [2:0]        code;
      mx   = b;
      mn   = b;
      maxp = CH_BLUE;
      minp = CH_BLUE;
      if (g > mx) begin
         mx   = g;
         maxp = CH_GREEN;
      end
      if (g < mn) begin
         mn   = g;
         minp = CH_GREEN;
      end
      if (r > mx) begin
         mx   = r;
         maxp = CH_RED;
      end
      if (r < mn) begin
         mn   = r;
         minp = CH_RED;
      end
      // With all three equal the mid channel is the common one.
      midp = (maxp == minp) ? maxp : 2'd3 - maxp - minp;
      case (midp)
         CH_BLUE:  md = b;
         CH_GREEN: md = g;
         default:  md = r;
      endcase
      up2    = {mx - md, 1'b0};
      dn     = {1'b0, mn == md ? 8'd0 : md - mn};
      mid_on = !(up2 > dn);
      // (mx + 2*md) / 3 > 100 is the same as mx + 2*md > 302.
      level  = {2'b00, mx} + {1'b0, md, 1'b0};
      all_on = level > 10'd302;
      if ((mx - mn) > 8'd60) begin
         code[2] = (maxp == CH_BLUE)  ? 1'b1 : (minp == CH_BLUE)  ? 1'b0 : mid_on;
         code[1] = (maxp == CH_GREEN) ? 1'b1 : (minp == CH_GREEN) ? 1'b0 : mid_on;
         code[0] = (maxp == CH_RED)   ? 1'b1 : (minp == CH_RED)   ? 1'b0 : mid_on;
      end else begin
         code = {3{all_on}};
      end
      return color_type'(code);
   endfunction

endpackage

// ----- rtl/core/cell_color_classifier.sv -----
// Top level of the cell color classifier: pixel accumulator and a short
// decision pipeline that turns one cell window into one color code.
// Depends on ccc_pkg.

// The block takes one BGR pixel per clock on the req_ stream and answers each
// window (closed by req_tlast) with one rsp_ transaction that carries the
// 3-bit color and, in rsp_tuser, whether a single pixel decided it. Pixels
// are summed per channel with saturation at 8191, and the first pixel of a
// window that matches a pure-color rule is latched and wins. Otherwise the
// sums are divided by CELL_PIXELS (a reciprocal multiply) and the averages go
// through the black test, the pure-color rules and a max/min/mid decision.
// Throughput is one pixel per cycle while req_tready is high, with no gap
// between windows. The edge that accepts the last pixel loads the finished
// sums; the averages register and then the output register, which holds the
// decision that is presented, are loaded after it in that order.
// req_tready drops only when the output is stalled and all
// finishing stages hold a window.
module cell_color_classifier
   import ccc_pkg::*;
#(
   parameter int CELL_PIXELS = CELL_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Pixel stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] blue, [15:8] green, [23:16] red
   input  logic                  req_tlast,
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] color, [7:3] zero
   output logic                  rsp_tuser    // [0] from_single_pixel
);

   // Reciprocal for the divide by CELL_PIXELS; exact for every 13-bit sum.
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'((2 ** DIV_SHIFT + CELL_PIXELS - 1) / CELL_PIXELS);
   localparam logic [SUM_W:0] SUM_MAX = {1'b0, {SUM_W{1'b1}}};

   // Sum divided by CELL_PIXELS, clamped to one channel.
   function automatic logic [CHAN_W-1:0] avg_of(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0]        prod;
      logic [PROD_W-DIV_SHIFT-1:0] quo;
      prod = PROD_W'(s) * PROD_W'(DIV_RECIP);
      quo  = prod[PROD_W-1:DIV_SHIFT];
      return (quo > (PROD_W-DIV_SHIFT)'(255)) ? 8'd255 : quo[CHAN_W-1:0];
   endfunction

   // Saturating add of one pixel channel to a running sum.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  s,
                                                input logic [CHAN_W-1:0] v);
      logic [SUM_W:0] t;
      t = {1'b0, s} + {{(SUM_W-CHAN_W+1){1'b0}}, v};
      return (t > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : t[SUM_W-1:0];
   endfunction

   logic [SUM_W-1:0]  sum_blue_ff, sum_green_ff, sum_red_ff;
   logic [SUM_W-1:0]  sum_blue_in, sum_green_in, sum_red_in;
   logic              early_hit_ff, early_hit_in;
   color_type         early_color_ff, early_color_in;

   logic              fin_valid_ff;
   logic [SUM_W-1:0]  fin_blue_ff, fin_green_ff, fin_red_ff;
   logic              fin_hit_ff;
   color_type         fin_color_ff;

   logic              avg_valid_ff;
   logic [CHAN_W-1:0] avg_blue_ff, avg_green_ff, avg_red_ff;
   logic              avg_hit_ff;
   color_type         avg_color_ff;

   logic              rsp_valid_ff;
   color_type         rsp_color_ff, rsp_color_in;
   logic              rsp_single_ff;

   logic              adv_rsp, adv_avg, adv_fin, req_fire;
   logic [CHAN_W-1:0] px_blue, px_green, px_red;
   color_type         px_match, avg_match;
   logic              hit_now;
   color_type         color_now;

   // Stage advance: each stage moves when the next one is empty or moving.
   assign adv_rsp    = !rsp_valid_ff || rsp_tready;
   assign adv_avg    = !avg_valid_ff || adv_rsp;
   assign adv_fin    = !fin_valid_ff || adv_avg;
   assign req_tready = adv_fin;
   assign req_fire   = req_tvalid && req_tready;

   assign px_blue  = req_tdata[7:0];
   assign px_green = req_tdata[15:8];
   assign px_red   = req_tdata[23:16];

   // Accumulate the pixel and latch the first pure-color match; a window's last pixel clears both.
   always_comb begin
      px_match  = pure_match(px_blue, px_green, px_red);
      hit_now   = early_hit_ff || (px_match != COLOR_BLACK);
      color_now = early_hit_ff ? early_color_ff : px_match;
      sum_blue_in    = sat_add(sum_blue_ff, px_blue);
      sum_green_in   = sat_add(sum_green_ff, px_green);
      sum_red_in     = sat_add(sum_red_ff, px_red);
      early_hit_in   = hit_now;
      early_color_in = color_now;
      if (req_tlast) begin
         sum_blue_in  = '0;
         sum_green_in = '0;
         sum_red_in   = '0;
         early_hit_in = 1'b0;
      end
   end

   // Final decision on the averages, unless a single pixel already decided.
   always_comb begin
      avg_match = pure_match(avg_blue_ff, avg_green_ff, avg_red_ff);
      if (avg_hit_ff) begin
         rsp_color_in = avg_color_ff;
      end else if (avg_blue_ff <= 8'd50 && avg_green_ff <= 8'd50 &&
                   avg_red_ff <= 8'd50) begin
         rsp_color_in = COLOR_BLACK;
      end else if (avg_match != COLOR_BLACK) begin
         rsp_color_in = avg_match;
      end else begin
         rsp_color_in = judge(avg_blue_ff, avg_green_ff, avg_red_ff);
      end
   end

   // Accumulator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_blue_ff    <= '0;
         sum_green_ff   <= '0;
         sum_red_ff     <= '0;
         early_hit_ff   <= 1'b0;
         early_color_ff <= COLOR_BLACK;
      end else if (req_fire) begin
         sum_blue_ff    <= sum_blue_in;
         sum_green_ff   <= sum_green_in;
         sum_red_ff     <= sum_red_in;
         early_hit_ff   <= early_hit_in;
         early_color_ff <= early_color_in;
      end
   end

   // Finished window: final sums and the latched match.
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv_fin) begin
         fin_valid_ff <= req_fire && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_fin) begin
         fin_blue_ff  <= sat_add(sum_blue_ff, px_blue);
         fin_green_ff <= sat_add(sum_green_ff, px_green);
         fin_red_ff   <= sat_add(sum_red_ff, px_red);
         fin_hit_ff   <= hit_now;
         fin_color_ff <= color_now;
      end
   end

   // Divider stage: channel averages.
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else if (adv_avg) begin
         avg_valid_ff <= fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_avg) begin
         avg_blue_ff  <= avg_of(fin_blue_ff);
         avg_green_ff <= avg_of(fin_green_ff);
         avg_red_ff   <= avg_of(fin_red_ff);
         avg_hit_ff   <= fin_hit_ff;
         avg_color_ff <= fin_color_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_rsp) begin
         rsp_valid_ff <= avg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_rsp) begin
         rsp_color_ff  <= rsp_color_in;
         rsp_single_ff <= avg_hit_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, rsp_color_ff};
   assign rsp_tuser  = rsp_single_ff;

   // A window's last pixel leaves the accumulator cleared.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> sum_blue_ff == '0 && sum_green_ff == '0 &&
                                sum_red_ff == '0 && !early_hit_ff)
      else $error("accumulator not cleared after last pixel");

   // A single-pixel decision is always a pure color, never black.
   a_single_not_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_single_ff |-> rsp_color_ff != COLOR_BLACK)
      else $error("single-pixel result is black");

   // A finished window moves into the divider stage with its match flag.
   a_fin_to_avg: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && adv_avg |=> avg_valid_ff && avg_hit_ff == $past(fin_hit_ff))
      else $error("finished window lost between stages");

   // With the finish stage empty the block always takes a pixel.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !fin_valid_ff |-> req_tready)
      else $error("pixel refused with free finish stage");

endmodule
